// File: design/dips_pkg.sv
// ----------------------------------------------------------------------------
// dips_pkg: shared definitions of the dual incremental PI speed controller
// Field widths, register indexes, reset values and the channel payload types.
// ----------------------------------------------------------------------------
`default_nettype none

package dips_pkg;

   // field widths
   localparam int SPEED_WIDTH     = 16;
   localparam int TARGET_WIDTH    = 16;
   localparam int GAIN_WIDTH      = 8;
   localparam int LIMIT_WIDTH     = 10;
   localparam int CMP_WIDTH       = 12;
   localparam int CSR_INDEX_WIDTH = 3;
   localparam int CSR_DATA_WIDTH  = 16;

   // error is target - speed at full precision
   localparam int ERR_WIDTH =
      ((SPEED_WIDTH > TARGET_WIDTH) ? SPEED_WIDTH : TARGET_WIDTH) + 1;

   // default divisor applied to the gain products
   localparam int GAIN_SCALE_DEF = 10;

   // register indexes
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_TARGET_A   = 3'd0;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_TARGET_B   = 3'd1;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_PROP_GAIN  = 3'd2;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_INTEG_GAIN = 3'd3;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_STEP_LIMIT = 3'd4;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_CEILING    = 3'd5;

   // reset values
   localparam logic signed [TARGET_WIDTH-1:0] TARGET_RESET = '0;
   localparam logic [GAIN_WIDTH-1:0]  PROP_GAIN_RESET  = 8'd30;
   localparam logic [GAIN_WIDTH-1:0]  INTEG_GAIN_RESET = 8'd50;
   localparam logic [LIMIT_WIDTH-1:0] STEP_LIMIT_RESET = 10'd80;
   localparam logic [CMP_WIDTH-1:0]   CEILING_RESET    = 12'd3199;
   localparam logic [CMP_WIDTH-1:0]   COMPARE_RESET    = 12'd3200;

   // input item
   typedef struct packed {
      logic signed [SPEED_WIDTH-1:0] speed_b;
      logic signed [SPEED_WIDTH-1:0] speed_a;
   } req_type;

   // result item
   typedef struct packed {
      logic [CMP_WIDTH-1:0] compare_b;
      logic [CMP_WIDTH-1:0] compare_a;
   } rsp_type;

   // configuration registers
   typedef struct packed {
      logic signed [TARGET_WIDTH-1:0] target_a;
      logic signed [TARGET_WIDTH-1:0] target_b;
      logic [GAIN_WIDTH-1:0]          prop_gain;
      logic [GAIN_WIDTH-1:0]          integ_gain;
      logic [LIMIT_WIDTH-1:0]         step_limit;
      logic [CMP_WIDTH-1:0]           compare_ceiling;
   } cfg_type;

   // stage load strobes from the pipeline control
   typedef struct packed {
      logic ld_s1;
      logic ld_s2;
      logic ld_out;
   } pipe_ctrl_type;

endpackage

`default_nettype wire

// File: design/dips_channel.sv
// ----------------------------------------------------------------------------
// dips_channel: datapath of one PI speed channel
// Error and gain products, saturating scaled division, compare value update.
// ----------------------------------------------------------------------------
`default_nettype none

module dips_channel #(
   parameter int GAIN_SCALE = dips_pkg::GAIN_SCALE_DEF
) (
   input  wire logic                                   clock,
   input  wire logic                                   reset,
   input  wire dips_pkg::pipe_ctrl_type                ctrl,
   input  wire dips_pkg::cfg_type                      cfg,
   input  wire logic signed [dips_pkg::TARGET_WIDTH-1:0] target,
   input  wire logic signed [dips_pkg::SPEED_WIDTH-1:0]  speed,
   output logic [dips_pkg::CMP_WIDTH-1:0]              compare
);

   localparam int EW   = dips_pkg::ERR_WIDTH;
   localparam int NW   = EW + 10;
   localparam int GW   = dips_pkg::GAIN_WIDTH;
   localparam int LW   = dips_pkg::LIMIT_WIDTH;
   localparam int CMW  = dips_pkg::CMP_WIDTH;
   localparam int GSW  = $clog2(GAIN_SCALE);
   // magnitudes below (step_limit + 1) * GAIN_SCALE fit in AW bits
   localparam int AW   = $clog2((1 << LW) * GAIN_SCALE);
   localparam int LSW  = AW + 1;
   localparam int SH   = AW + GSW;
   localparam int MW   = AW + 1;
   localparam int PW   = AW + MW;
   localparam int KW   = (NW > LSW) ? NW : LSW;
   localparam longint unsigned RECIP_FULL =
      ((64'd1 << SH) + 64'(GAIN_SCALE) - 64'd1) / 64'(GAIN_SCALE);
   localparam logic [MW-1:0] RECIP = MW'(RECIP_FULL);

   // stage 1: error and gain products
   logic signed [EW-1:0] err_in;
   logic signed [EW:0]   diff_in;
   logic signed [GW:0]   kp_s;
   logic signed [GW:0]   ki_s;
   logic signed [NW-1:0] prod_p_in;
   logic signed [NW-1:0] prod_i_in;
   logic signed [EW-1:0] prev_error_ff;
   logic signed [NW-1:0] prod_p_ff;
   logic signed [NW-1:0] prod_i_ff;

   assign err_in    = EW'(target) - EW'(speed);
   assign diff_in   = (EW+1)'(err_in) - (EW+1)'(prev_error_ff);
   assign kp_s      = signed'({1'b0, cfg.prop_gain});
   assign ki_s      = signed'({1'b0, cfg.integ_gain});
   assign prod_p_in = NW'(kp_s) * NW'(diff_in);
   assign prod_i_in = NW'(ki_s) * NW'(err_in);

   // stage 2: sum, magnitude and saturation test
   logic signed [NW-1:0] num;
   logic [NW-1:0]        mag;
   logic                 sat_in;
   logic [LSW-1:0]       lim_scaled_in;
   logic [LSW-1:0]       lim_scaled_ff;
   logic                 neg_ff;
   logic                 sat_ff;
   logic [AW-1:0]        mag_ff;

   assign num           = prod_p_ff + prod_i_ff;
   assign mag           = num[NW-1] ? unsigned'(-num) : unsigned'(num);
   assign sat_in        = KW'(mag) >= KW'(lim_scaled_ff);
   assign lim_scaled_in = LSW'((32'(cfg.step_limit) + 32'd1) * GAIN_SCALE);

   // output stage: quotient by reciprocal, step, clamp
   logic [PW-1:0]  quot_prod;
   logic [LW-1:0]  step;
   logic [CMW:0]   raise;
   logic [CMW-1:0] lower;
   logic [CMW-1:0] compare_in;
   logic [CMW-1:0] compare_ff;

   assign quot_prod = PW'(mag_ff) * PW'(RECIP);
   assign step      = sat_ff ? cfg.step_limit : quot_prod[SH +: LW];
   assign raise     = {1'b0, compare_ff} + (CMW+1)'(step);
   assign lower     = compare_ff - CMW'(step);

   // negative step raises the compare value, positive lowers it
   always_comb begin
      if (neg_ff) begin
         if (raise > {1'b0, cfg.compare_ceiling}) begin
            compare_in = cfg.compare_ceiling;
         end else begin
            compare_in = raise[CMW-1:0];
         end
      end else if (compare_ff < CMW'(step)) begin
         compare_in = '0;
      end else if (lower > cfg.compare_ceiling) begin
         compare_in = cfg.compare_ceiling;
      end else begin
         compare_in = lower;
      end
   end

   // channel state
   always_ff @(posedge clock) begin
      if (reset) begin
         prev_error_ff <= '0;
         compare_ff    <= dips_pkg::COMPARE_RESET;
      end else begin
         if (ctrl.ld_s1) begin
            prev_error_ff <= err_in;
         end
         if (ctrl.ld_out) begin
            compare_ff <= compare_in;
         end
      end
   end

   // pipeline payload
   always_ff @(posedge clock) begin
      lim_scaled_ff <= lim_scaled_in;
      if (ctrl.ld_s1) begin
         prod_p_ff <= prod_p_in;
         prod_i_ff <= prod_i_in;
      end
      if (ctrl.ld_s2) begin
         neg_ff <= num[NW-1];
         sat_ff <= sat_in;
         mag_ff <= mag[AW-1:0];
      end
   end

   assign compare = compare_ff;

   // compare value stays under the ceiling that was in force at the update
   a_under_ceiling: assert property (@(posedge clock) disable iff (reset)
      ctrl.ld_out |=> (compare_ff <= $past(cfg.compare_ceiling)))
      else $error("compare value above ceiling");

   // a positive step never raises the compare value
   a_lower_dir: assert property (@(posedge clock) disable iff (reset)
      (ctrl.ld_out && !neg_ff) |=> (compare_ff <= $past(compare_ff)))
      else $error("compare value rose on positive step");

   // reset restores the channel state
   a_reset_state: assert property (@(posedge clock)
      reset |=> (compare_ff == dips_pkg::COMPARE_RESET) && (prev_error_ff == '0))
      else $error("channel state not restored by reset");

endmodule

`default_nettype wire

// File: design/dual_incremental_pi_speed.sv
// ----------------------------------------------------------------------------
// dual_incremental_pi_speed: two-channel incremental PI speed controller
// Path: an accepted item passes the input register, product stage, saturation
//   stage and compare register before rsp_valid.
// Throughput: one item per cycle; the pipeline stalls only when rsp_stall
//   holds a full output with every stage behind it occupied.
// Reset: clears all valids, restores register defaults, errors to 0 and
//   both compare values to 3200.
// ----------------------------------------------------------------------------
`default_nettype none

module dual_incremental_pi_speed #(
   parameter int GAIN_SCALE = dips_pkg::GAIN_SCALE_DEF
) (
   input  wire logic                                     clock,
   input  wire logic                                     reset,
   input  wire logic                                     req_valid,
   output logic                                          req_stall,
   input  wire dips_pkg::req_type                        req_data,
   output logic                                          rsp_valid,
   input  wire logic                                     rsp_stall,
   output dips_pkg::rsp_type                             rsp_data,
   input  wire logic                                     csr_wr_en,
   input  wire logic [dips_pkg::CSR_INDEX_WIDTH-1:0]     csr_index,
   input  wire logic [dips_pkg::CSR_DATA_WIDTH-1:0]      csr_wr_data
);

   localparam int CMW = dips_pkg::CMP_WIDTH;

   dips_pkg::cfg_type       cfg_ff;
   dips_pkg::req_type       req_data_ff;
   dips_pkg::pipe_ctrl_type ctrl;

   logic in_valid_ff;
   logic s1_valid_ff;
   logic s2_valid_ff;
   logic rsp_valid_ff;
   logic adv_out;
   logic adv_s2;
   logic adv_s1;
   logic req_accept;
   logic [CMW-1:0] cmp_a;
   logic [CMW-1:0] cmp_b;

   // a stage moves on when the next one is empty or moving
   assign adv_out     = !rsp_valid_ff || !rsp_stall;
   assign adv_s2      = !s2_valid_ff || adv_out;
   assign adv_s1      = !s1_valid_ff || adv_s2;
   assign req_stall   = in_valid_ff && !adv_s1;
   assign req_accept  = req_valid && !req_stall;
   assign ctrl.ld_s1  = in_valid_ff && adv_s1;
   assign ctrl.ld_s2  = s1_valid_ff && adv_s2;
   assign ctrl.ld_out = s2_valid_ff && adv_out;

   // valid bits and configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff            <= 1'b0;
         s1_valid_ff            <= 1'b0;
         s2_valid_ff            <= 1'b0;
         rsp_valid_ff           <= 1'b0;
         cfg_ff.target_a        <= dips_pkg::TARGET_RESET;
         cfg_ff.target_b        <= dips_pkg::TARGET_RESET;
         cfg_ff.prop_gain       <= dips_pkg::PROP_GAIN_RESET;
         cfg_ff.integ_gain      <= dips_pkg::INTEG_GAIN_RESET;
         cfg_ff.step_limit      <= dips_pkg::STEP_LIMIT_RESET;
         cfg_ff.compare_ceiling <= dips_pkg::CEILING_RESET;
      end else begin
         if (req_accept) begin
            in_valid_ff <= 1'b1;
         end else if (ctrl.ld_s1) begin
            in_valid_ff <= 1'b0;
         end
         if (ctrl.ld_s1) begin
            s1_valid_ff <= 1'b1;
         end else if (ctrl.ld_s2) begin
            s1_valid_ff <= 1'b0;
         end
         if (ctrl.ld_s2) begin
            s2_valid_ff <= 1'b1;
         end else if (ctrl.ld_out) begin
            s2_valid_ff <= 1'b0;
         end
         if (ctrl.ld_out) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
         if (csr_wr_en) begin
            unique case (csr_index)
               dips_pkg::CSR_TARGET_A:   cfg_ff.target_a   <= signed'(csr_wr_data[15:0]);
               dips_pkg::CSR_TARGET_B:   cfg_ff.target_b   <= signed'(csr_wr_data[15:0]);
               dips_pkg::CSR_PROP_GAIN:  cfg_ff.prop_gain  <= csr_wr_data[7:0];
               dips_pkg::CSR_INTEG_GAIN: cfg_ff.integ_gain <= csr_wr_data[7:0];
               dips_pkg::CSR_STEP_LIMIT: cfg_ff.step_limit <= csr_wr_data[9:0];
               dips_pkg::CSR_CEILING:    cfg_ff.compare_ceiling <= csr_wr_data[11:0];
               default: begin
               end
            endcase
         end
      end
   end

   // input register
   always_ff @(posedge clock) begin
      if (req_accept) begin
         req_data_ff <= req_data;
      end
   end

   // channel datapaths
   dips_channel #(.GAIN_SCALE(GAIN_SCALE)) u_chan_a (
      .clock   (clock),
      .reset   (reset),
      .ctrl    (ctrl),
      .cfg     (cfg_ff),
      .target  (cfg_ff.target_a),
      .speed   (req_data_ff.speed_a),
      .compare (cmp_a)
   );

   dips_channel #(.GAIN_SCALE(GAIN_SCALE)) u_chan_b (
      .clock   (clock),
      .reset   (reset),
      .ctrl    (ctrl),
      .cfg     (cfg_ff),
      .target  (cfg_ff.target_b),
      .speed   (req_data_ff.speed_b),
      .compare (cmp_b)
   );

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_data.compare_a = cmp_a;
   assign rsp_data.compare_b = cmp_b;

   // input is held back only while the input register is occupied
   a_stall_full: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> in_valid_ff)
      else $error("input stalled with empty input register");

   // an item leaving the last stage shows up as a result
   a_out_loaded: assert property (@(posedge clock) disable iff (reset)
      ctrl.ld_out |=> rsp_valid_ff)
      else $error("result lost at output register");

   // a delivered result with nothing behind it leaves the output empty
   a_out_drain: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_stall && !s2_valid_ff) |=> !rsp_valid_ff)
      else $error("result repeated after delivery");

   // reset empties the pipeline
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !in_valid_ff && !s1_valid_ff && !s2_valid_ff && !rsp_valid_ff)
      else $error("pipeline not empty after reset");

endmodule

`default_nettype wire
